// ----- rtl/core/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ptns_pkg.sv -----
package ptns_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int NEAREST_MIN     = 3;
	localparam int FIRST_SLOT      = 1;

	localparam int COORD_W  = 16;
	localparam int KIND_W   = 2;
	localparam int OP_W     = 2;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int DIST_W   = 34;
	localparam int SQ_W     = 2 * COORD_W;

	localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
	localparam logic [OP_W-1:0] OP_NEAREST = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [KIND_W-1:0]  kind;
	} entry_t;

	// tag that travels with a scanned entry through the distance unit
	typedef struct packed {
		logic valid;
		logic last;
	} dtag_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
		logic [IDX_W-1:0]          found_index;
		logic [DIST_W-1:0]         distance_sq;
		logic signed [COORD_W-1:0] read_x;
		logic signed [COORD_W-1:0] read_y;
		logic [KIND_W-1:0]         read_kind;
	} result_t;

endpackage

// ----- rtl/core/ptns_if.sv -----
interface ptns_req_if;
	logic                                valid;
	logic                                ready;
	logic [ptns_pkg::OP_W-1:0]           opcode;
	logic signed [ptns_pkg::COORD_W-1:0] pos_x;
	logic signed [ptns_pkg::COORD_W-1:0] pos_y;
	logic [ptns_pkg::KIND_W-1:0]         kind;
	logic [ptns_pkg::IDX_W-1:0]          index;

	modport source (output valid, opcode, pos_x, pos_y, kind, index, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, kind, index, output ready);
endinterface

interface ptns_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [ptns_pkg::STATUS_W-1:0]       status;
	logic [ptns_pkg::COUNT_W-1:0]        count;
	logic [ptns_pkg::IDX_W-1:0]          found_index;
	logic [ptns_pkg::DIST_W-1:0]         distance_sq;
	logic signed [ptns_pkg::COORD_W-1:0] read_x;
	logic signed [ptns_pkg::COORD_W-1:0] read_y;
	logic [ptns_pkg::KIND_W-1:0]         read_kind;

	modport source (output valid, status, count, found_index, distance_sq,
		read_x, read_y, read_kind, input ready);
	modport sink (input valid, status, count, found_index, distance_sq,
		read_x, read_y, read_kind, output ready);
endinterface

// ----- rtl/core/ptns_ram.sv -----
module ptns_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/ptns_dist.sv -----
module ptns_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptns_pkg::dtag_t                    tag_in,
	input  logic [ptns_pkg::COORD_W-1:0]       ref_x,
	input  logic [ptns_pkg::COORD_W-1:0]       ref_y,
	input  logic [ptns_pkg::COORD_W-1:0]       ent_x,
	input  logic [ptns_pkg::COORD_W-1:0]       ent_y,
	output ptns_pkg::dtag_t                    tag_out,
	output logic [ptns_pkg::DIST_W-1:0]        dist_sq
);

	localparam int CW = ptns_pkg::COORD_W;

	logic [CW:0]                    dx, dy, ax, ay;
	logic [CW-1:0]                  mag_x_s1, mag_y_s1;
	logic [ptns_pkg::SQ_W-1:0]      sq_x_s2, sq_y_s2;
	logic [ptns_pkg::DIST_W-1:0]    dist_s3;
	ptns_pkg::dtag_t                tag_s1, tag_s2, tag_s3;

	// sign-extended difference, then magnitude (fits in CW bits)
	always_comb begin
		dx = {ent_x[CW-1], ent_x} - {ref_x[CW-1], ref_x};
		dy = {ent_y[CW-1], ent_y} - {ref_y[CW-1], ref_y};
		ax = dx[CW] ? (~dx + 1'b1) : dx;
		ay = dy[CW] ? (~dy + 1'b1) : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_x_s1 <= ax[CW-1:0];
		mag_y_s1 <= ay[CW-1:0];
		sq_x_s2  <= mag_x_s1 * mag_x_s1;
		sq_y_s2  <= mag_y_s1 * mag_y_s1;
		dist_s3  <= ptns_pkg::DIST_W'(sq_x_s2) + ptns_pkg::DIST_W'(sq_y_s2);
	end

	assign tag_out = tag_s3;
	assign dist_sq = dist_s3;

endmodule

// ----- rtl/core/point_table_nearest_swap.sv -----
// point table with nearest-entry search
// req channel: one transfer carries an operation (add, remove, nearest, read) with
// a point, a kind and a slot index; rsp channel returns exactly one transfer
// per request with status, entry count after the operation, nearest slot and
// squared distance, or the entry read
// the nearest scan reads one stored entry per cycle through the single read
// port of the entry memory and pushes it through a shared three-stage
// squared-distance unit, then the swap into slot one reads slot one and the
// best slot and writes each into the other's place
// one request is in work at a time; req ready is high only while idle
// a finished response sits in an output register, so the next request is
// taken while rsp is stalled; its response waits until that register drains
// reset empties the table (count zero); entry memory has no reset and no
// clearing pass, slots are only used after they have been written
module point_table_nearest_swap #(
	parameter int TABLE_DEPTH = ptns_pkg::TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ptns_req_if.sink        req,
	ptns_rsp_if.source      rsp
);

	`include "assert_macros.svh"

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > ptns_pkg::IDX_W) ? CNT_W : ptns_pkg::IDX_W;
	localparam int OCNT_W = (CNT_W > ptns_pkg::COUNT_W) ? CNT_W : ptns_pkg::COUNT_W;
	localparam int FND_W  = (ADDR_W > ptns_pkg::IDX_W) ? ADDR_W : ptns_pkg::IDX_W;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_RM_WR = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_SW_A  = 4'd6;
	localparam logic [3:0] S_SW_B  = 4'd7;
	localparam logic [3:0] S_SW_C  = 4'd8;
	localparam logic [3:0] S_SW_D  = 4'd9;
	localparam logic [3:0] S_RESP  = 4'd10;

	logic [3:0]                       state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [ADDR_W-1:0]                scan_i_q, cmp_i_q, best_q;
	logic [ptns_pkg::DIST_W-1:0]      best_d_q;
	logic                             have_q;
	logic                             out_v_q;
	ptns_pkg::dtag_t                  rd_tag_q;
	ptns_pkg::result_t                res_q, out_q;
	ptns_pkg::result_t                exec_res, out_d;
	ptns_pkg::entry_t                 swap_q;

	logic [ptns_pkg::OP_W-1:0]        op_q;
	logic [ptns_pkg::COORD_W-1:0]     px_q, py_q;
	logic [ptns_pkg::KIND_W-1:0]      kind_q;
	logic [ptns_pkg::IDX_W-1:0]       idx_q;

	// memory port
	logic                             ram_we;
	logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
	ptns_pkg::entry_t                 ram_wdata, ram_rdata;

	// distance unit
	ptns_pkg::dtag_t                  iss_tag, dtag_out;
	logic [ptns_pkg::DIST_W-1:0]      dist_out;

	logic                             acc, out_free;
	logic                             full, idx_bad, too_few, scan_last, better;
	logic [CNT_W-1:0]                 cnt_m1;
	logic [CMP_W-1:0]                 idx_ext, cnt_ext;
	logic [ADDR_W-1:0]                idx_addr, last_addr;
	logic [OCNT_W-1:0]                cnt_out;
	logic [FND_W-1:0]                 found_ext;

	assign acc      = req.valid && req.ready;
	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// operation checks against the current fill
	assign cnt_m1    = cnt_q - 1'b1;
	assign idx_ext   = CMP_W'(idx_q);
	assign cnt_ext   = CMP_W'(cnt_q);
	assign full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign idx_bad   = (idx_ext >= cnt_ext);
	assign too_few   = (cnt_q < CNT_W'(ptns_pkg::NEAREST_MIN));
	assign idx_addr  = idx_ext[ADDR_W-1:0];
	assign last_addr = cnt_m1[ADDR_W-1:0];
	assign scan_last = (CNT_W'(scan_i_q) == cnt_m1);
	// first strict minimum wins
	assign better    = !have_q || (dist_out < best_d_q);
	assign cnt_out   = OCNT_W'(cnt_q);
	assign found_ext = FND_W'(best_q);

	assign iss_tag.valid = (state_q == S_SCAN);
	assign iss_tag.last  = scan_last;

	// status of the operation, decided in the execute cycle
	always_comb begin
		exec_res = '0;
		case (op_q)
			ptns_pkg::OP_ADD: begin
				if (full) begin
					exec_res.status = ptns_pkg::ST_FULL;
				end
			end
			ptns_pkg::OP_NEAREST: begin
				if (too_few) begin
					exec_res.status = ptns_pkg::ST_TOO_FEW;
				end
			end
			default: begin
				if (idx_bad) begin
					exec_res.status = ptns_pkg::ST_BAD_INDEX;
				end
			end
		endcase
	end

	// response with the count after the operation
	always_comb begin
		out_d       = res_q;
		out_d.count = cnt_out[ptns_pkg::COUNT_W-1:0];
	end

	// memory address and write selection per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = last_addr;
		ram_wdata = ram_rdata;
		ram_raddr = scan_i_q;
		case (state_q)
			S_EXEC: begin
				if (op_q == ptns_pkg::OP_ADD && !full) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[ADDR_W-1:0];
					ram_wdata = '{x: px_q, y: py_q, kind: kind_q};
				end
				if (op_q == ptns_pkg::OP_REMOVE) begin
					ram_raddr = last_addr;
				end else begin
					ram_raddr = idx_addr;
				end
			end
			S_RM_WR: begin
				// last entry moves into the freed slot
				ram_we    = 1'b1;
				ram_waddr = idx_addr;
			end
			S_SW_A: ram_raddr = ADDR_W'(ptns_pkg::FIRST_SLOT);
			S_SW_B: ram_raddr = best_q;
			S_SW_C: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(ptns_pkg::FIRST_SLOT);
			end
			S_SW_D: begin
				ram_we    = 1'b1;
				ram_waddr = best_q;
				ram_wdata = swap_q;
			end
			default: ;
		endcase
	end

	ptns_ram #(
		.WIDTH($bits(ptns_pkg::entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared squared-distance unit, fed one entry per cycle during the scan
	ptns_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (rd_tag_q),
		.ref_x   (px_q),
		.ref_y   (py_q),
		.ent_x   (ram_rdata.x),
		.ent_y   (ram_rdata.y),
		.tag_out (dtag_out),
		.dist_sq (dist_out)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			scan_i_q <= '0;
			cmp_i_q  <= '0;
			have_q   <= 1'b0;
			out_v_q  <= 1'b0;
			rd_tag_q <= '0;
		end else begin
			// tag lines up with the registered memory read
			rd_tag_q <= iss_tag;
			if (dtag_out.valid) begin
				cmp_i_q <= cmp_i_q + 1'b1;
				have_q  <= 1'b1;
			end
			if (state_q == S_RESP && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						ptns_pkg::OP_ADD: begin
							if (!full) begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= S_RESP;
						end
						ptns_pkg::OP_REMOVE: state_q <= idx_bad ? S_RESP : S_RM_WR;
						ptns_pkg::OP_READ:   state_q <= idx_bad ? S_RESP : S_RD;
						ptns_pkg::OP_NEAREST: begin
							if (too_few) begin
								state_q <= S_RESP;
							end else begin
								scan_i_q <= ADDR_W'(ptns_pkg::FIRST_SLOT);
								cmp_i_q  <= ADDR_W'(ptns_pkg::FIRST_SLOT);
								have_q   <= 1'b0;
								state_q  <= S_SCAN;
							end
						end
						default: state_q <= S_RESP;
					endcase
				end
				S_RM_WR: begin
					cnt_q   <= cnt_m1;
					state_q <= S_RESP;
				end
				S_RD: state_q <= S_RESP;
				S_SCAN: begin
					scan_i_q <= scan_i_q + 1'b1;
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (dtag_out.valid && dtag_out.last) begin
						state_q <= S_SW_A;
					end
				end
				S_SW_A: state_q <= S_SW_B;
				S_SW_B: state_q <= S_SW_C;
				S_SW_C: state_q <= S_SW_D;
				S_SW_D: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= req.opcode;
			px_q   <= req.pos_x;
			py_q   <= req.pos_y;
			kind_q <= req.kind;
			idx_q  <= req.index;
		end
		if (dtag_out.valid && better) begin
			best_d_q <= dist_out;
			best_q   <= cmp_i_q;
		end
		case (state_q)
			S_EXEC: res_q <= exec_res;
			S_RD: begin
				res_q.read_x    <= ram_rdata.x;
				res_q.read_y    <= ram_rdata.y;
				res_q.read_kind <= ram_rdata.kind;
			end
			S_SW_B: swap_q <= ram_rdata;
			S_SW_D: begin
				res_q.found_index <= found_ext[ptns_pkg::IDX_W-1:0];
				res_q.distance_sq <= best_d_q;
			end
			S_RESP: begin
				if (out_free) begin
					out_q <= out_d;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_q.status;
	assign rsp.count       = out_q.count;
	assign rsp.found_index = out_q.found_index;
	assign rsp.distance_sq = out_q.distance_sq;
	assign rsp.read_x      = out_q.read_x;
	assign rsp.read_y      = out_q.read_y;
	assign rsp.read_kind   = out_q.read_kind;

	// fill changes only where add or remove commits
	`ASSERT_NEXT(a_cnt_commit, state_q != S_EXEC && state_q != S_RM_WR, cnt_q == $past(cnt_q), "count changed outside add or remove")
	// distance results arrive only while the scan runs or drains
	`ASSERT_IMPL(a_dist_in_scan, dtag_out.valid, state_q == S_SCAN || state_q == S_DRAIN, "distance result outside scan")
	// during the swap reads, the best slot lies inside the filled part of the table
	`ASSERT_IMPL(a_best_range, have_q && (state_q == S_SW_A || state_q == S_SW_B), best_q < cnt_q, "nearest slot beyond count")

endmodule

// ----- verif/tb_point_table_nearest_swap.sv -----
module tb_point_table_nearest_swap;
	import ptns_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// long receiver hold-off, long enough to back the block up into its request side
	localparam int HOLD_CYCLES = 300;
	// random requests per idling phase
	localparam int PHASE_ITEMS = 325;
	// quiet cycles after the last response, well above the nearest latency
	localparam int TAIL_CYCLES = 80;

	// tracks the table contents and checks each response against the predicted one
	class point_table_tracker;
		entry_t      slots[TABLE_DEPTH_DEF];
		int unsigned entry_count;
		result_t     pending[$];
		int          errors;
		int          op_seen[4];
		int          status_seen[4];

		function new();
			entry_count = 0;
			errors = 0;
			foreach (slots[i]) slots[i] = '0;
			foreach (op_seen[i]) op_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function automatic longint sq_diff(logic [COORD_W-1:0] stored,
			logic signed [COORD_W-1:0] anchor);
			int d;
			d = int'($signed(stored)) - int'(anchor);
			return longint'(d) * longint'(d);
		endfunction

		// apply one accepted request to the table copy and queue its response
		function void note_request(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py, logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
			result_t want;
			entry_t  held;
			longint  best_d;
			longint  d;
			int      best;
			want = '0;
			want.status = ST_OK;
			case (op)
				OP_ADD: begin
					if (entry_count >= TABLE_DEPTH_DEF) begin
						want.status = ST_FULL;
					end else begin
						slots[entry_count] = '{x: px, y: py, kind: kind};
						entry_count++;
					end
				end
				OP_REMOVE: begin
					if (idx >= entry_count) begin
						want.status = ST_BAD_INDEX;
					end else begin
						// last entry fills the hole, which is a no-op for the last slot
						slots[idx] = slots[entry_count - 1];
						entry_count--;
					end
				end
				OP_NEAREST: begin
					if (entry_count < NEAREST_MIN) begin
						want.status = ST_TOO_FEW;
					end else begin
						best = FIRST_SLOT;
						best_d = 0;
						for (int i = FIRST_SLOT; i < entry_count; i++) begin
							d = sq_diff(slots[i].x, px) + sq_diff(slots[i].y, py);
							// strict compare keeps the first of equal distances
							if (i == FIRST_SLOT || d < best_d) begin
								best_d = d;
								best = i;
							end
						end
						held = slots[FIRST_SLOT];
						slots[FIRST_SLOT] = slots[best];
						slots[best] = held;
						want.found_index = best;
						want.distance_sq = best_d;
					end
				end
				default: begin
					if (idx >= entry_count) begin
						want.status = ST_BAD_INDEX;
					end else begin
						want.read_x = slots[idx].x;
						want.read_y = slots[idx].y;
						want.read_kind = slots[idx].kind;
					end
				end
			endcase
			want.count = entry_count;
			op_seen[op]++;
			status_seen[want.status]++;
			pending.push_back(want);
		endfunction

		function void compare_field(string name, logic [DIST_W-1:0] want,
			logic [DIST_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_response(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: response with nothing outstanding, actual status %0h count %0h",
					$time, got.status, got.count);
				return;
			end
			want = pending.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("count", want.count, got.count);
			compare_field("found_index", want.found_index, got.found_index);
			compare_field("distance_sq", want.distance_sq, got.distance_sq);
			compare_field("read_x", {18'b0, want.read_x}, {18'b0, got.read_x});
			compare_field("read_y", {18'b0, want.read_y}, {18'b0, got.read_y});
			compare_field("read_kind", want.read_kind, got.read_kind);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ptns_req_if req_ch ();
	ptns_rsp_if rsp_ch ();

	point_table_nearest_swap u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	point_table_tracker sb = new();

	// sender idling is owned by the stimulus process
	int src_idle_pct;
	// receiver stall rate and hold-off request are handed over with nonblocking writes
	int sink_stall_pct;
	logic hold_toggle;
	logic hold_seen;
	int hold_left;
	int fill_target;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off each time hold_toggle flips
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// response monitor; reads the values that stood before the edge
	always @(posedge clk) begin : rsp_monitor
		result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.count = rsp_ch.count;
			got.found_index = rsp_ch.found_index;
			got.distance_sq = rsp_ch.distance_sq;
			got.read_x = rsp_ch.read_x;
			got.read_y = rsp_ch.read_y;
			got.read_kind = rsp_ch.read_kind;
			sb.check_response(got);
		end
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d responses outstanding",
				$time, STALL_LIMIT, sb.pending.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// one request transfer; valid stays high after the handshake so that
	// back-to-back requests never lower and raise it in one step
	task automatic send_op(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] px,
		logic signed [COORD_W-1:0] py, logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.pos_x <= px;
		req_ch.pos_y <= py;
		req_ch.kind <= kind;
		req_ch.index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(op, px, py, kind, idx);
	endtask

	// sender goes quiet until every outstanding response has come back
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// half wide random, some corners, some coarse grid values that make ties
	function automatic logic signed [COORD_W-1:0] pick_coord();
		int m;
		logic signed [COORD_W-1:0] v;
		m = $urandom_range(9);
		if (m < 5) begin
			v = $urandom;
		end else if (m < 7) begin
			case ($urandom_range(3))
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = 16'sh0000;
				default: v = 16'shffff;
			endcase
		end else begin
			v = $urandom_range(4) * 16 - 32;
		end
		return v;
	endfunction

	// steer the table toward fill_target so that empty, small and full tables all occur
	task automatic random_request();
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		int r;
		int unsigned have;
		have = sb.entry_count;
		r = $urandom_range(99);
		if (have < fill_target) begin
			op = (r < 60) ? OP_ADD : (r < 75) ? OP_NEAREST : (r < 90) ? OP_READ : OP_REMOVE;
		end else if (have > fill_target) begin
			op = (r < 50) ? OP_REMOVE : (r < 70) ? OP_NEAREST : (r < 90) ? OP_READ : OP_ADD;
		end else begin
			op = (r < 25) ? OP_ADD : (r < 50) ? OP_REMOVE : (r < 75) ? OP_NEAREST : OP_READ;
		end
		// mostly valid slots, the rest anywhere in the index range
		if (have != 0 && $urandom_range(9) < 8) begin
			idx = $urandom_range(have - 1);
		end else begin
			idx = $urandom_range(31);
		end
		send_op(op, pick_coord(), pick_coord(), $urandom_range(3), idx);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ADD;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.kind = '0;
		req_ch.index = '0;
		rsp_ch.ready = 1'b0;
		hold_toggle = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		sink_stall_pct = 0;
		src_idle_pct = 0;
		fill_target = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table errors
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		send_op(OP_NEAREST, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		// corner coordinates, nearest refused with two entries
		send_op(OP_ADD, 16'sh8000, 16'sh8000, 2'd0, 5'd0);
		send_op(OP_ADD, 16'sh8000, 16'sh8000, 2'd2, 5'd0);
		send_op(OP_NEAREST, 16'sh7fff, 16'sh7fff, 2'd0, 5'd0);
		// kind 3 stored as given; opposite corner gives the largest distance,
		// the tie keeps slot one so the swap does nothing
		send_op(OP_ADD, 16'sh8000, 16'sh8000, 2'd3, 5'd0);
		send_op(OP_NEAREST, 16'sh7fff, 16'sh7fff, 2'd1, 5'd0);
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd1);
		// exact hit on a later slot, swapped into slot one
		send_op(OP_ADD, 16'sh7fff, 16'sh7fff, 2'd1, 5'd0);
		send_op(OP_NEAREST, 16'sh7fff, 16'sh7fff, 2'd0, 5'd0);
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd1);
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd3);
		// alternating bit patterns
		send_op(OP_ADD, 16'sh5555, 16'shaaaa, 2'd1, 5'd0);
		send_op(OP_NEAREST, 16'shaaaa, 16'sh5555, 2'd3, 5'd31);
		// out of range reads
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd31);
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd5);
		// remove of the last slot, removes that move the last entry, one out of range, until empty
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd4);
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		send_op(OP_READ, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		send_op(OP_REMOVE, 16'sh7fff, 16'sh7fff, 2'd3, 5'd31);
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd1);
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		send_op(OP_REMOVE, 16'sh0000, 16'sh0000, 2'd0, 5'd0);
		wait_for_drain();

		// random phases: no idling, sender idle, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct = 73;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct <= 73;
				end
				default: begin
					src_idle_pct = 30;
					sink_stall_pct <= 30;
				end
			endcase
			// long receiver hold-off while requests keep coming
			if (ph == 0 || ph == 2) hold_toggle <= ~hold_toggle;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					case ($urandom_range(5))
						0: fill_target = 0;
						1: fill_target = NEAREST_MIN;
						2, 3: fill_target = TABLE_DEPTH_DEF;
						default: fill_target = $urandom_range(TABLE_DEPTH_DEF);
					endcase
				end
				random_request();
			end
			wait_for_drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d add, %0d remove, %0d nearest, %0d read requests",
			sb.op_seen[OP_ADD], sb.op_seen[OP_REMOVE], sb.op_seen[OP_NEAREST],
			sb.op_seen[OP_READ]);
		$display("status seen: %0d ok, %0d full, %0d bad index, %0d too few",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_BAD_INDEX],
			sb.status_seen[ST_TOO_FEW]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
